[rtl/core/nms_pkg.sv]
// Package with the shared constants, types and control structures of the box suppression block.
`timescale 1ns / 1ps
package nms_pkg;

    localparam int MaxBoxes = 64;
    localparam int AddrW    = $clog2(MaxBoxes);
    localparam int CntW     = AddrW + 1;
    localparam int ThrW     = 17;
    localparam int KeepW    = 7;
    localparam int RankW    = 6;
    localparam int CfgIdxW  = 1;
    localparam int CfgDataW = 17;

    localparam logic [CfgIdxW-1:0] CfgThr  = 1'b0;
    localparam logic [CfgIdxW-1:0] CfgKeep = 1'b1;

    localparam logic [ThrW-1:0]  ThrReset  = 17'd29491;
    localparam logic [KeepW-1:0] KeepReset = 7'd64;
    localparam logic [KeepW-1:0] KeepLimit = 7'd64;

    typedef struct packed {
        logic [15:0] x1;
        logic [15:0] y1;
        logic [15:0] x2;
        logic [15:0] y2;
        logic [15:0] score;
        logic [7:0]  cls;
    } t_box;

    typedef struct packed {
        logic             in_ready;
        logic             st_we;
        logic [AddrW-1:0] st_waddr;
        logic [AddrW-1:0] st_raddr;
        logic             st_src_rank;
        logic             lat_si;
        logic             cnt_clr;
        logic             rk_issue;
        logic [AddrW-1:0] rk_j;
        logic [AddrW-1:0] cur_i;
        logic             rk_we;
        logic [AddrW-1:0] rk_raddr;
        logic             lat_a;
        logic             keep;
        logic             push;
        logic             push_last;
        logic             pr_issue;
        logic [AddrW-1:0] pr_j;
        logic             supp_clr;
        logic [RankW-1:0] emit_rank;
    } t_cmd;

    typedef struct packed {
        logic supp_cur;
        logic pipe_busy;
        logic out_free;
        logic pend_valid;
        logic supp_none;
    } t_sts;

endpackage

[rtl/core/nms_in_if.sv]
// Interface for the box input channel.
`timescale 1ns / 1ps
interface nms_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] box_x1;
    logic [15:0] box_y1;
    logic [15:0] box_x2;
    logic [15:0] box_y2;
    logic [15:0] box_score;
    logic [7:0]  box_class;
    logic        last_box;

    modport source (output valid, box_x1, box_y1, box_x2, box_y2, box_score, box_class,
                     last_box, input ready);
    modport sink (input valid, box_x1, box_y1, box_x2, box_y2, box_score, box_class,
                   last_box, output ready);
endinterface

[rtl/core/nms_out_if.sv]
// Interface for the kept box output channel.
`timescale 1ns / 1ps
interface nms_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_x1;
    logic [15:0] out_y1;
    logic [15:0] out_x2;
    logic [15:0] out_y2;
    logic [15:0] out_score;
    logic [7:0]  out_class;
    logic [5:0]  rank;
    logic        last_kept;

    modport source (output valid, out_x1, out_y1, out_x2, out_y2, out_score, out_class,
                     rank, last_kept, input ready);
    modport sink (input valid, out_x1, out_y1, out_x2, out_y2, out_score, out_class,
                   rank, last_kept, output ready);
endinterface

[rtl/core/class_aware_box_nms.sv]
// Top level of the class-aware greedy box suppression block.
//
//  channel   direction  transaction                  handshake
//  i_box     in         one detection box            valid / ready
//  o_kept    out        one kept box with its rank   valid / ready
//  i_cfg_*   in         one register write           write enable only
//
// Boxes load one per cycle. Ranking compares each box with every stored box, one store read
// per cycle. Suppression walks the ranked boxes through the GA, GB and GC states; each kept
// box then issues one overlap test per later box and waits for the overlap pipeline to drain.
// Reset is synchronous and active low; a stalled output holds the walk at the next kept box.
`timescale 1ns / 1ps
module class_aware_box_nms (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [nms_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [nms_pkg::CfgDataW-1:0] i_cfg_data,
    nms_in_if.sink                       i_box,
    nms_out_if.source                    o_kept
);
    import nms_pkg::*;

    logic [ThrW-1:0]  r_thr;
    logic [KeepW-1:0] r_max_keep;
    t_cmd             w_cmd;
    t_sts             w_sts;
    t_box             w_in_box;
    t_box             w_out_box;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr      <= ThrReset;
            r_max_keep <= KeepReset;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CfgThr:  r_thr      <= i_cfg_data[ThrW-1:0];
                CfgKeep: r_max_keep <= i_cfg_data[KeepW-1:0];
                default: r_thr      <= r_thr;
            endcase
        end
    end

    assign w_in_box.x1    = i_box.box_x1;
    assign w_in_box.y1    = i_box.box_y1;
    assign w_in_box.x2    = i_box.box_x2;
    assign w_in_box.y2    = i_box.box_y2;
    assign w_in_box.score = i_box.box_score;
    assign w_in_box.cls   = i_box.box_class;
    assign i_box.ready    = w_cmd.in_ready;

    nms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_box.valid),
        .i_in_last  (i_box.last_box),
        .i_max_keep (r_max_keep),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    nms_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_box       (w_in_box),
        .i_thr       (r_thr),
        .i_out_ready (o_kept.ready),
        .o_out_valid (o_kept.valid),
        .o_out_box   (w_out_box),
        .o_out_rank  (o_kept.rank),
        .o_out_last  (o_kept.last_kept),
        .o_sts       (w_sts)
    );

    assign o_kept.out_x1    = w_out_box.x1;
    assign o_kept.out_y1    = w_out_box.y1;
    assign o_kept.out_x2    = w_out_box.x2;
    assign o_kept.out_y2    = w_out_box.y2;
    assign o_kept.out_score = w_out_box.score;
    assign o_kept.out_class = w_out_box.cls;

    a_load_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.in_ready |-> (w_sts.supp_none && !w_sts.pend_valid && !w_sts.pipe_busy))
        else $error("loading started with leftover suppression state");

    a_rank_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_kept.valid && o_kept.ready) |-> (KeepW'(o_kept.rank) < r_max_keep))
        else $error("kept box rank beyond the keep limit");

    a_keep_no_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.keep |-> !w_sts.pipe_busy)
        else $error("box kept while overlap tests still in flight");
endmodule

[rtl/core/nms_ctrl.sv]
// Controller state machine that sequences loading, ranking, suppression and emission.
`timescale 1ns / 1ps
module nms_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_last,
    input  logic [nms_pkg::KeepW-1:0] i_max_keep,
    input  nms_pkg::t_sts             i_sts,
    output nms_pkg::t_cmd             o_cmd
);
    import nms_pkg::*;

    typedef enum logic [13:0] {
        S_LOAD  = 14'b00000000000001,
        S_RK_A  = 14'b00000000000010,
        S_RK_AW = 14'b00000000000100,
        S_RK_SW = 14'b00000000001000,
        S_RK_DR = 14'b00000000010000,
        S_RK_WR = 14'b00000000100000,
        S_GA    = 14'b00000001000000,
        S_GB    = 14'b00000010000000,
        S_GC    = 14'b00000100000000,
        S_KEEP  = 14'b00001000000000,
        S_SW    = 14'b00010000000000,
        S_DRAIN = 14'b00100000000000,
        S_FLUSH = 14'b01000000000000,
        S_CLR   = 14'b10000000000000
    } t_state;

    t_state            r_state, n_state;
    logic [CntW-1:0]   r_cnt, n_cnt;
    logic [CntW-1:0]   r_i, n_i;
    logic [CntW-1:0]   r_j, n_j;
    logic [KeepW-1:0]  r_emit, n_emit;
    logic [KeepW-1:0]  w_cap;
    logic [CntW-1:0]   w_i_inc;
    logic [CntW-1:0]   w_j_inc;

    assign w_cap   = (i_max_keep > KeepLimit) ? KeepLimit : i_max_keep;
    assign w_i_inc = r_i + CntW'(1);
    assign w_j_inc = r_j + CntW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_emit  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_i     <= n_i;
            r_j     <= n_j;
            r_emit  <= n_emit;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_i     = r_i;
        n_j     = r_j;
        n_emit  = r_emit;
        o_cmd             = '0;
        o_cmd.st_waddr    = r_cnt[AddrW-1:0];
        o_cmd.cur_i       = r_i[AddrW-1:0];
        o_cmd.emit_rank   = r_emit[RankW-1:0];
        o_cmd.rk_j        = r_j[AddrW-1:0];
        o_cmd.pr_j        = r_j[AddrW-1:0];
        case (r_state)
            S_LOAD: begin
                o_cmd.in_ready = 1'b1;
                if (i_in_valid) begin
                    if (r_cnt < CntW'(MaxBoxes)) begin
                        o_cmd.st_we = 1'b1;
                        n_cnt       = r_cnt + CntW'(1);
                    end
                    if (i_in_last) begin
                        n_i     = '0;
                        n_state = S_RK_A;
                    end
                end
            end
            S_RK_A: begin
                o_cmd.st_raddr = r_i[AddrW-1:0];
                o_cmd.cnt_clr  = 1'b1;
                n_state        = S_RK_AW;
            end
            S_RK_AW: begin
                o_cmd.lat_si = 1'b1;
                n_j          = '0;
                n_state      = S_RK_SW;
            end
            S_RK_SW: begin
                o_cmd.st_raddr = r_j[AddrW-1:0];
                o_cmd.rk_issue = 1'b1;
                n_j            = w_j_inc;
                if (w_j_inc == r_cnt) begin
                    n_state = S_RK_DR;
                end
            end
            S_RK_DR: begin
                n_state = S_RK_WR;
            end
            S_RK_WR: begin
                o_cmd.rk_we = 1'b1;
                if (w_i_inc == r_cnt) begin
                    n_i    = '0;
                    n_emit = '0;
                    n_state = (w_cap == '0) ? S_CLR : S_GA;
                end else begin
                    n_i     = w_i_inc;
                    n_state = S_RK_A;
                end
            end
            S_GA: begin
                o_cmd.rk_raddr = r_i[AddrW-1:0];
                n_state        = S_GB;
            end
            S_GB: begin
                o_cmd.st_src_rank = 1'b1;
                n_state           = S_GC;
            end
            S_GC: begin
                o_cmd.lat_a = 1'b1;
                if (!i_sts.supp_cur) begin
                    n_state = S_KEEP;
                end else if (w_i_inc == r_cnt) begin
                    n_state = S_FLUSH;
                end else begin
                    n_i     = w_i_inc;
                    n_state = S_GA;
                end
            end
            S_KEEP: begin
                if (!i_sts.pend_valid || i_sts.out_free) begin
                    o_cmd.push = i_sts.pend_valid;
                    o_cmd.keep = 1'b1;
                    n_emit     = r_emit + KeepW'(1);
                    if ((r_emit + KeepW'(1)) == w_cap || w_i_inc == r_cnt) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_j     = w_i_inc;
                        n_state = S_SW;
                    end
                end
            end
            S_SW: begin
                o_cmd.pr_issue    = 1'b1;
                o_cmd.rk_raddr    = r_j[AddrW-1:0];
                o_cmd.st_src_rank = 1'b1;
                n_j               = w_j_inc;
                if (w_j_inc == r_cnt) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                o_cmd.st_src_rank = 1'b1;
                if (!i_sts.pipe_busy) begin
                    if (w_i_inc == r_cnt) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_i     = w_i_inc;
                        n_state = S_GA;
                    end
                end
            end
            S_FLUSH: begin
                if (!i_sts.pend_valid) begin
                    n_state = S_CLR;
                end else if (i_sts.out_free) begin
                    o_cmd.push      = 1'b1;
                    o_cmd.push_last = 1'b1;
                    n_state         = S_CLR;
                end
            end
            S_CLR: begin
                o_cmd.supp_clr = 1'b1;
                n_cnt          = '0;
                n_state        = S_LOAD;
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end
endmodule

[rtl/core/nms_dp.sv]
// Datapath with the box stores, rank table, overlap test pipeline and output registers.
`timescale 1ns / 1ps
module nms_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  nms_pkg::t_cmd             i_cmd,
    input  nms_pkg::t_box             i_box,
    input  logic [nms_pkg::ThrW-1:0]  i_thr,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output nms_pkg::t_box             o_out_box,
    output logic [nms_pkg::RankW-1:0] o_out_rank,
    output logic                      o_out_last,
    output nms_pkg::t_sts             o_sts
);
    import nms_pkg::*;

    t_box             r_store [MaxBoxes];
    logic [AddrW-1:0] r_ranked [MaxBoxes];
    t_box             r_store_q;
    logic [AddrW-1:0] r_rank_q;
    logic [AddrW-1:0] w_st_addr;

    logic [15:0]      r_si;
    logic [AddrW-1:0] r_cmp;
    logic             r_rk_v;
    logic [AddrW-1:0] r_rk_j;

    t_box             r_a;
    t_box             r_pend;
    logic [RankW-1:0] r_pend_rank;
    logic             r_pend_v;
    logic             r_ov;
    logic [MaxBoxes-1:0] r_supp;

    logic                    r_p1_v, r_p2_v, r_p3_v, r_p4_v, r_p5_v, r_p6_v;
    logic [AddrW-1:0]        r_p1_j, r_p2_j, r_p3_j, r_p4_j, r_p5_j, r_p6_j;
    logic [15:0]             r_dx, r_dy;
    logic signed [16:0]      r_wa, r_ha, r_wb, r_hb;
    logic [31:0]             r_inter4, r_inter5, r_inter6;
    logic signed [33:0]      r_area_a, r_area_b;
    logic signed [35:0]      r_uni;
    logic                    r_pos;
    logic [34:0]             r_prod_lo;
    logic [33:0]             r_prod_hi;

    logic [15:0]        w_ix1, w_iy1, w_ix2, w_iy2;
    logic signed [16:0] w_dx, w_dy;
    logic [52:0]        w_rhs;
    logic [52:0]        w_lhs;
    logic               w_out_free;

    assign w_st_addr  = i_cmd.st_src_rank ? r_rank_q : i_cmd.st_raddr;
    assign w_out_free = !r_ov || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.st_we) begin
            r_store[i_cmd.st_waddr] <= i_box;
        end
        r_store_q <= r_store[w_st_addr];
        if (i_cmd.rk_we) begin
            r_ranked[r_cmp] <= i_cmd.cur_i;
        end
        r_rank_q <= r_ranked[i_cmd.rk_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lat_si) begin
            r_si <= r_store_q.score;
        end
        if (i_cmd.lat_a) begin
            r_a <= r_store_q;
        end
        if (i_cmd.keep) begin
            r_pend      <= r_a;
            r_pend_rank <= i_cmd.emit_rank;
        end
        if (i_cmd.push) begin
            o_out_box  <= r_pend;
            o_out_rank <= r_pend_rank;
            o_out_last <= i_cmd.push_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rk_v   <= 1'b0;
            r_cmp    <= '0;
            r_pend_v <= 1'b0;
            r_ov     <= 1'b0;
            r_supp   <= '0;
        end else begin
            r_rk_v <= i_cmd.rk_issue;
            if (i_cmd.cnt_clr) begin
                r_cmp <= '0;
            end else if (r_rk_v && ((r_store_q.score > r_si) ||
                         (r_store_q.score == r_si && r_rk_j < i_cmd.cur_i))) begin
                r_cmp <= r_cmp + AddrW'(1);
            end
            if (i_cmd.keep) begin
                r_pend_v <= 1'b1;
            end else if (i_cmd.push) begin
                r_pend_v <= 1'b0;
            end
            if (i_cmd.push) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
            if (i_cmd.supp_clr) begin
                r_supp <= '0;
            end else if (r_p6_v && r_pos && (w_lhs > w_rhs)) begin
                r_supp[r_p6_j] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rk_j <= i_cmd.rk_j;
    end

    always_comb begin
        w_ix1 = (r_a.x1 > r_store_q.x1) ? r_a.x1 : r_store_q.x1;
        w_iy1 = (r_a.y1 > r_store_q.y1) ? r_a.y1 : r_store_q.y1;
        w_ix2 = (r_a.x2 < r_store_q.x2) ? r_a.x2 : r_store_q.x2;
        w_iy2 = (r_a.y2 < r_store_q.y2) ? r_a.y2 : r_store_q.y2;
        w_dx  = $signed({1'b0, w_ix2}) - $signed({1'b0, w_ix1});
        w_dy  = $signed({1'b0, w_iy2}) - $signed({1'b0, w_iy1});
        w_lhs = {5'd0, r_inter6, 16'd0};
        w_rhs = {1'b0, r_prod_hi, 18'd0} + {18'd0, r_prod_lo};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_p3_v <= 1'b0;
            r_p4_v <= 1'b0;
            r_p5_v <= 1'b0;
            r_p6_v <= 1'b0;
        end else begin
            r_p1_v <= i_cmd.pr_issue && !r_supp[i_cmd.pr_j];
            r_p2_v <= r_p1_v;
            r_p3_v <= r_p2_v && (r_store_q.cls == r_a.cls);
            r_p4_v <= r_p3_v;
            r_p5_v <= r_p4_v;
            r_p6_v <= r_p5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_j <= i_cmd.pr_j;
        r_p2_j <= r_p1_j;
        r_p3_j <= r_p2_j;
        r_p4_j <= r_p3_j;
        r_p5_j <= r_p4_j;
        r_p6_j <= r_p5_j;

        r_dx <= w_dx[16] ? 16'd0 : w_dx[15:0];
        r_dy <= w_dy[16] ? 16'd0 : w_dy[15:0];
        r_wa <= $signed({1'b0, r_a.x2}) - $signed({1'b0, r_a.x1});
        r_ha <= $signed({1'b0, r_a.y2}) - $signed({1'b0, r_a.y1});
        r_wb <= $signed({1'b0, r_store_q.x2}) - $signed({1'b0, r_store_q.x1});
        r_hb <= $signed({1'b0, r_store_q.y2}) - $signed({1'b0, r_store_q.y1});

        r_inter4 <= r_dx * r_dy;
        r_area_a <= 34'(r_wa * r_ha);
        r_area_b <= 34'(r_wb * r_hb);

        r_inter5 <= r_inter4;
        r_uni    <= 36'(r_area_a) + 36'(r_area_b) - $signed({4'd0, r_inter4});

        r_inter6  <= r_inter5;
        r_pos     <= (r_uni > 36'sd0);
        r_prod_lo <= i_thr * r_uni[17:0];
        r_prod_hi <= i_thr * r_uni[34:18];
    end

    assign o_out_valid     = r_ov;
    assign o_sts.supp_cur  = r_supp[i_cmd.cur_i];
    assign o_sts.pipe_busy = r_p1_v | r_p2_v | r_p3_v | r_p4_v | r_p5_v | r_p6_v;
    assign o_sts.out_free  = w_out_free;
    assign o_sts.pend_valid = r_pend_v;
    assign o_sts.supp_none = (r_supp == '0);
endmodule
